// ===== sv/cfft2d_pkg.sv =====
// ----------------------------------------------------------------------------
// cfft2d_pkg
// types, constants and twiddle table for the 2-D fixed point fft
// ----------------------------------------------------------------------------
package cfft2d_pkg;

    localparam int DIM      = 8;
    localparam int LOG2_DIM = 3;
    localparam int NPTS     = DIM * DIM;
    localparam int AW       = 2 * LOG2_DIM;
    localparam int WW       = 32;

    typedef struct packed {
        logic signed [15:0] real_in;
        logic signed [15:0] imag_in;
    } t_in;

    typedef struct packed {
        logic signed [31:0] real_out;
        logic signed [31:0] imag_out;
        logic               last_out;
    } t_out;

    typedef enum logic [3:0] {
        S_LOAD,
        S_BR_RD,
        S_BR_WAIT,
        S_BR_WR,
        S_BF_RD,
        S_BF_WAIT,
        S_BF_MUL,
        S_BF_WR,
        S_SC_RD,
        S_SC_WAIT,
        S_SC_WR,
        S_TR_RD,
        S_TR_WAIT,
        S_TR_WR,
        S_OUT_RD,
        S_OUT_SHOW
    } t_state;

    // quarter-wave cosine, q15, 1.0 held as 32768
    function automatic logic signed [16:0] cos_q15(input logic [4:0] k);
        case (k)
            5'd0:    cos_q15 = 17'sd32768;
            5'd1:    cos_q15 = 17'sd32610;
            5'd2:    cos_q15 = 17'sd32138;
            5'd3:    cos_q15 = 17'sd31357;
            5'd4:    cos_q15 = 17'sd30274;
            5'd5:    cos_q15 = 17'sd28899;
            5'd6:    cos_q15 = 17'sd27246;
            5'd7:    cos_q15 = 17'sd25330;
            5'd8:    cos_q15 = 17'sd23170;
            5'd9:    cos_q15 = 17'sd20788;
            5'd10:   cos_q15 = 17'sd18205;
            5'd11:   cos_q15 = 17'sd15447;
            5'd12:   cos_q15 = 17'sd12540;
            5'd13:   cos_q15 = 17'sd9512;
            5'd14:   cos_q15 = 17'sd6393;
            5'd15:   cos_q15 = 17'sd3212;
            default: cos_q15 = 17'sd0;
        endcase
    endfunction

endpackage

// ===== sv/cfft2d_ram.sv =====
// ----------------------------------------------------------------------------
// cfft2d_ram
// generic single write, dual read ram with registered read data
// ----------------------------------------------------------------------------
module cfft2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== sv/complex_fft_2d_unit.sv =====
// ----------------------------------------------------------------------------
// complex_fft_2d_unit
// 2-D radix-2 fft, row-column, with one shared butterfly unit
// ----------------------------------------------------------------------------
// flow: load, then in each pass every row gets bit reversal, butterflies (two reads, one
//   multiply stage, two writes) and, for inverse, scaling; a transpose lies between passes
// throughput: one sample per cycle while loading and the sender holds valid high; each
//   result is then read from ram and shown before the next one is read
// reset: synchronous active low, clears state, counters and direction
module complex_fft_2d_unit
    import cfft2d_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_state r_state, n_state;
    logic   r_dir, r_inv, n_inv;
    logic [AW:0]         r_cnt, n_cnt;       // load / entry counter
    logic [LOG2_DIM-1:0] r_row, n_row;
    logic [LOG2_DIM-1:0] r_col, n_col;
    logic [LOG2_DIM-1:0] r_stg, n_stg;
    logic [LOG2_DIM-1:0] r_bj, n_bj;         // butterfly index within row
    logic                r_pass, n_pass;
    logic                r_wsel, n_wsel;     // second write of a pair
    logic signed [WW-1:0] r_ar, r_ai, r_br, r_bi, n_ar, n_ai, n_br, n_bi;
    logic signed [WW-1:0] r_tr, r_ti, n_tr, n_ti;

    // ram ports
    logic          we;
    logic [AW-1:0] waddr, ra, rb;
    logic [2*WW-1:0] wdata, qa, qb;

    cfft2d_ram #(.WIDTH(2 * WW), .DEPTH(NPTS)) u_ram (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr_a(ra),
        .i_raddr_b(rb),
        .o_rdata_a(qa),
        .o_rdata_b(qb)
    );

    // bit reversal of a column index
    function automatic logic [LOG2_DIM-1:0] brev(input logic [LOG2_DIM-1:0] v);
        for (int i = 0; i < LOG2_DIM; i++) begin
            brev[i] = v[LOG2_DIM-1-i];
        end
    endfunction

    // butterfly geometry for the current stage and index
    logic [LOG2_DIM-1:0] half, jj, grp, idx_i, idx_k;
    logic [4:0]          tw;
    logic signed [16:0]  tc, ts, tws;
    always_comb begin
        half  = LOG2_DIM'(1) << r_stg;
        jj    = r_bj & (half - LOG2_DIM'(1));
        grp   = (r_bj >> r_stg) << (r_stg + LOG2_DIM'(1));
        idx_i = grp | jj;
        idx_k = idx_i | half;
        tw    = 5'((6'(jj) << (6'd5 - 6'(r_stg))));
        if (tw <= 5'd16) begin
            tc = cos_q15(tw);
            ts = cos_q15(5'd16 - tw);
        end else begin
            tc = -cos_q15(5'd0 - tw);
            ts = cos_q15(tw - 5'd16);
        end
        tws = r_inv ? ts : -ts;
    end

    // shared complex multiply, registered before the add
    logic signed [49:0] pr, pim;
    always_comb begin
        pr  = 50'(tc) * 50'(r_br) - 50'(tws) * 50'(r_bi) + 50'sd16384;
        pim = 50'(tc) * 50'(r_bi) + 50'(tws) * 50'(r_br) + 50'sd16384;
    end

    logic [AW-1:0] cnt_a;
    assign cnt_a = r_cnt[AW-1:0];

    // sequencer
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_row = r_row; n_col = r_col;
        n_stg = r_stg; n_bj = r_bj; n_pass = r_pass; n_wsel = r_wsel;
        n_inv = r_inv;
        n_ar = r_ar; n_ai = r_ai; n_br = r_br; n_bi = r_bi;
        n_tr = r_tr; n_ti = r_ti;
        we = 1'b0; waddr = cnt_a; wdata = '0; ra = cnt_a; rb = cnt_a;
        o_ready = 1'b0; o_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_ready = 1'b1;
                waddr   = cnt_a;
                wdata   = {WW'(i_data.real_in), WW'(i_data.imag_in)};
                if (i_valid) begin
                    we = 1'b1;
                    if (r_cnt == (AW+1)'(NPTS - 1)) begin
                        n_cnt = '0; n_inv = r_dir; n_row = '0; n_col = '0;
                        n_pass = 1'b0; n_state = S_BR_RD;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            // bit reversal swap
            S_BR_RD: begin
                if (r_col < brev(r_col)) begin
                    ra = {r_row, r_col}; rb = {r_row, brev(r_col)};
                    n_state = S_BR_WAIT;
                end else if (r_col == LOG2_DIM'(DIM - 1)) begin
                    n_col = '0; n_stg = '0; n_bj = '0; n_state = S_BF_RD;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_BR_WAIT: begin
                n_ar = qa[2*WW-1:WW]; n_ai = qa[WW-1:0];
                n_br = qb[2*WW-1:WW]; n_bi = qb[WW-1:0];
                n_wsel = 1'b0; n_state = S_BR_WR;
            end
            S_BR_WR: begin
                we = 1'b1;
                if (!r_wsel) begin
                    waddr = {r_row, r_col}; wdata = {r_br, r_bi}; n_wsel = 1'b1;
                end else begin
                    waddr = {r_row, brev(r_col)}; wdata = {r_ar, r_ai};
                    n_state = S_BR_RD;
                    if (r_col == LOG2_DIM'(DIM - 1)) begin
                        n_col = '0; n_stg = '0; n_bj = '0; n_state = S_BF_RD;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            // butterflies
            S_BF_RD: begin
                ra = {r_row, idx_i}; rb = {r_row, idx_k}; n_state = S_BF_WAIT;
            end
            S_BF_WAIT: begin
                n_ar = qa[2*WW-1:WW]; n_ai = qa[WW-1:0];
                n_br = qb[2*WW-1:WW]; n_bi = qb[WW-1:0];
                n_state = S_BF_MUL;
            end
            S_BF_MUL: begin
                n_tr = WW'(pr >>> 15); n_ti = WW'(pim >>> 15);
                n_wsel = 1'b0; n_state = S_BF_WR;
            end
            S_BF_WR: begin
                we = 1'b1;
                if (!r_wsel) begin
                    waddr = {r_row, idx_i}; wdata = {r_ar + r_tr, r_ai + r_ti};
                    n_wsel = 1'b1;
                end else begin
                    waddr = {r_row, idx_k}; wdata = {r_ar - r_tr, r_ai - r_ti};
                    n_state = S_BF_RD;
                    if (r_bj == LOG2_DIM'(DIM / 2 - 1)) begin
                        n_bj = '0;
                        if (r_stg == LOG2_DIM'(LOG2_DIM - 1)) begin
                            n_stg = '0; n_col = '0;
                            if (r_inv) begin
                                n_state = S_SC_RD;
                            end else if (r_row == LOG2_DIM'(DIM - 1)) begin
                                n_row = '0; n_state = r_pass ? S_OUT_RD : S_TR_RD;
                                n_cnt = '0;
                            end else begin
                                n_row = r_row + 1'b1; n_state = S_BR_RD;
                            end
                        end else begin
                            n_stg = r_stg + 1'b1;
                        end
                    end else begin
                        n_bj = r_bj + 1'b1;
                    end
                end
            end
            // inverse scaling of one row
            S_SC_RD: begin
                ra = {r_row, r_col}; n_state = S_SC_WAIT;
            end
            S_SC_WAIT: begin
                n_ar = qa[2*WW-1:WW]; n_ai = qa[WW-1:0]; n_state = S_SC_WR;
            end
            S_SC_WR: begin
                we = 1'b1; waddr = {r_row, r_col};
                wdata = {r_ar >>> LOG2_DIM, r_ai >>> LOG2_DIM};
                n_state = S_SC_RD;
                if (r_col == LOG2_DIM'(DIM - 1)) begin
                    n_col = '0;
                    if (r_row == LOG2_DIM'(DIM - 1)) begin
                        n_row = '0; n_cnt = '0;
                        n_state = r_pass ? S_OUT_RD : S_TR_RD;
                    end else begin
                        n_row = r_row + 1'b1; n_state = S_BR_RD;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            // transpose, swapping each entry below the diagonal
            S_TR_RD: begin
                if (r_col < r_row) begin
                    ra = {r_row, r_col}; rb = {r_col, r_row}; n_state = S_TR_WAIT;
                end else if (r_row == LOG2_DIM'(DIM - 1)) begin
                    n_row = '0; n_col = '0; n_pass = 1'b1; n_state = S_BR_RD;
                end else begin
                    n_row = r_row + 1'b1; n_col = '0;
                end
            end
            S_TR_WAIT: begin
                n_ar = qa[2*WW-1:WW]; n_ai = qa[WW-1:0];
                n_br = qb[2*WW-1:WW]; n_bi = qb[WW-1:0];
                n_wsel = 1'b0; n_state = S_TR_WR;
            end
            S_TR_WR: begin
                we = 1'b1;
                if (!r_wsel) begin
                    waddr = {r_row, r_col}; wdata = {r_br, r_bi}; n_wsel = 1'b1;
                end else begin
                    waddr = {r_col, r_row}; wdata = {r_ar, r_ai};
                    n_col = r_col + 1'b1; n_state = S_TR_RD;
                end
            end
            // result transfer
            S_OUT_RD: begin
                ra = cnt_a; n_state = S_OUT_SHOW;
            end
            S_OUT_SHOW: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (r_cnt == (AW+1)'(NPTS - 1)) begin
                        n_cnt = '0; n_state = S_LOAD;
                    end else begin
                        n_cnt = r_cnt + 1'b1; n_state = S_OUT_RD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // output payload straight from the registered read port
    assign o_data.real_out = qa[2*WW-1:WW];
    assign o_data.imag_out = qa[WW-1:0];
    assign o_data.last_out = (r_cnt == (AW+1)'(NPTS - 1));

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_cnt <= '0; r_dir <= 1'b0; r_inv <= 1'b0;
            r_row <= '0; r_col <= '0; r_stg <= '0; r_bj <= '0;
            r_pass <= 1'b0; r_wsel <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_inv <= n_inv;
            r_row <= n_row; r_col <= n_col; r_stg <= n_stg; r_bj <= n_bj;
            r_pass <= n_pass; r_wsel <= n_wsel;
            if (i_cfg_we) begin
                r_dir <= i_cfg_data;
            end
        end
        r_ar <= n_ar; r_ai <= n_ai; r_br <= n_br; r_bi <= n_bi;
        r_tr <= n_tr; r_ti <= n_ti;
    end

    // checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    a_load_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && r_cnt == (AW+1)'(NPTS - 1) |=> r_state == S_BR_RD)
        else $error("transform did not start");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks the 2-D fixed point fft: whole matrices of random and edge-case
// samples are streamed in, a local row-column fft predicts the transposed
// spectrum, and every result transfer is compared field by field
// ----------------------------------------------------------------------------
module tb_top;
    import cfft2d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data = '0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_data = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    complex_fft_2d_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] mat_re [NPTS];
    logic signed [31:0] mat_im [NPTS];
    int   fill_count = 0;
    logic inverse_mode = 1'b0;

    t_in  sample_queue [$];
    t_out spectrum_queue [$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   mismatches = 0;
    int   result_count = 0;
    int   cycle_count = 0;
    int   matrices = 0;
    bit   pause_sender = 1'b0;

    function automatic longint cos_tab(input int k);
        int tab [17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                         23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
        return tab[k];
    endfunction

    // signed q15 twiddle for angle 2*pi*t/64
    function automatic void twiddle_q15(input int t, output longint c, output longint s);
        int u;
        u = t & 31;
        if (u <= 16) begin
            c = cos_tab(u);
            s = cos_tab(16 - u);
        end else begin
            c = -cos_tab(32 - u);
            s = cos_tab(u - 16);
        end
    endfunction

    // one in-place 1-D fft over DIM consecutive entries starting at base
    function automatic void fft_line(input int base, input bit inv);
        logic signed [31:0] xr [DIM];
        logic signed [31:0] xi [DIM];
        logic signed [31:0] tmp, tr, ti;
        longint c, s, ws, pr, pim;
        int rev, half;
        for (int i = 0; i < DIM; i++) begin
            xr[i] = mat_re[base + i];
            xi[i] = mat_im[base + i];
        end
        for (int i = 0; i < DIM; i++) begin
            rev = 0;
            for (int b = 0; b < LOG2_DIM; b++) rev |= ((i >> b) & 1) << (LOG2_DIM - 1 - b);
            if (i < rev) begin
                tmp = xr[i]; xr[i] = xr[rev]; xr[rev] = tmp;
                tmp = xi[i]; xi[i] = xi[rev]; xi[rev] = tmp;
            end
        end
        for (int l = 0; l < LOG2_DIM; l++) begin
            half = 1 << l;
            for (int j = 0; j < half; j++) begin
                twiddle_q15(j << (5 - l), c, s);
                ws = inv ? s : -s;
                for (int i = j; i + half < DIM; i += 2 * half) begin
                    pr  = c * longint'(xr[i + half]) - ws * longint'(xi[i + half]);
                    pim = c * longint'(xi[i + half]) + ws * longint'(xr[i + half]);
                    tr = 32'((pr + 16384) >>> 15);
                    ti = 32'((pim + 16384) >>> 15);
                    xr[i + half] = xr[i] - tr;
                    xi[i + half] = xi[i] - ti;
                    xr[i] = xr[i] + tr;
                    xi[i] = xi[i] + ti;
                end
            end
        end
        for (int i = 0; i < DIM; i++) begin
            mat_re[base + i] = inv ? (xr[i] >>> LOG2_DIM) : xr[i];
            mat_im[base + i] = inv ? (xi[i] >>> LOG2_DIM) : xi[i];
        end
    endfunction

    // load one sample; on the last one compute and queue the spectrum
    function automatic void predict_sample(input t_in smp);
        logic signed [31:0] tmp;
        t_out res;
        mat_re[fill_count] = 32'(smp.real_in);
        mat_im[fill_count] = 32'(smp.imag_in);
        fill_count++;
        if (fill_count < NPTS) return;
        fill_count = 0;
        matrices++;
        for (int r = 0; r < DIM; r++) fft_line(r * DIM, inverse_mode);
        for (int r = 0; r < DIM; r++)
            for (int c = 0; c < r; c++) begin
                tmp = mat_re[r*DIM+c]; mat_re[r*DIM+c] = mat_re[c*DIM+r];
                mat_re[c*DIM+r] = tmp;
                tmp = mat_im[r*DIM+c]; mat_im[r*DIM+c] = mat_im[c*DIM+r];
                mat_im[c*DIM+r] = tmp;
            end
        for (int r = 0; r < DIM; r++) fft_line(r * DIM, inverse_mode);
        for (int k = 0; k < NPTS; k++) begin
            res.real_out = mat_re[k];
            res.imag_out = mat_im[k];
            res.last_out = (k == NPTS - 1);
            spectrum_queue.push_back(res);
        end
    endfunction

    // transfer seen at the last rising edge
    bit sent_last = 1'b0;
    always @(posedge i_clk) begin
        sent_last <= i_valid && o_ready && i_rst_n;
    end

    // sender: drive at falling edge, keep payload until transfer
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || sent_last) begin
                if (sample_queue.size() > 0 && !pause_sender &&
                    $urandom_range(99) >= send_idle_pct) begin
                    i_data  <= sample_queue.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // accepted samples feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) predict_sample(i_data);
    end

    // result check
    always @(posedge i_clk) begin
        t_out exp_res;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            result_count++;
            if (spectrum_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result re=%0d im=%0d last=%0b",
                             o_data.real_out, o_data.imag_out, o_data.last_out);
            end else begin
                exp_res = spectrum_queue.pop_front();
                if (o_data !== exp_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at result %0d: exp re=%0d im=%0d last=%0b,",
                                  " got re=%0d im=%0d last=%0b"},
                                 result_count, exp_res.real_out, exp_res.imag_out,
                                 exp_res.last_out, o_data.real_out, o_data.imag_out,
                                 o_data.last_out);
                end
            end
        end
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_matrix(input int kind);
        t_in smp;
        for (int k = 0; k < NPTS; k++) begin
            case (kind)
                0: smp = t_in'{16'sh7fff, 16'sh8000};
                1: smp = t_in'{16'sh8000, 16'sh7fff};
                2: smp = (k == 0) ? t_in'{16'sh7fff, 16'sh0000} : t_in'(0);
                default: begin
                    smp.real_in = 16'($urandom);
                    smp.imag_in = 16'($urandom);
                    if ($urandom_range(9) == 0)
                        smp.real_in = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                    if ($urandom_range(9) == 0)
                        smp.imag_in = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                end
            endcase
            sample_queue.push_back(smp);
        end
    endtask

    // wait until all queued samples are transferred and all results are back
    task automatic drain();
        while (sample_queue.size() > 0 || i_valid || spectrum_queue.size() > 0 || fill_count != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_direction(input bit inv);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= inv;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        inverse_mode = inv;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: forward and inverse extremes
        send_idle_pct = 8; recv_idle_pct = 54;
        add_matrix(0);
        drain();
        set_direction(1'b1);
        add_matrix(1);
        drain();

        // random forward data with the idling swapped
        send_idle_pct = 54; recv_idle_pct = 8;
        set_direction(1'b0);
        add_matrix(3);
        while (sample_queue.size() > 0 || i_valid) @(posedge i_clk);
        // hold the next matrix until the pending spectrum is fully back
        pause_sender = 1'b1;
        send_idle_pct = 0; recv_idle_pct = 0;
        add_matrix(3);
        while (spectrum_queue.size() > 0) @(posedge i_clk);
        pause_sender = 1'b0;
        drain();

        $display("covered %0d matrices, %0d results, both directions, edge and random data",
                 matrices, result_count);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/cfft2d_pkg.sv
sv/cfft2d_ram.sv
sv/complex_fft_2d_unit.sv
tb/tb_top.sv
